// File: design/tbi_pkg.sv
// Shared types, constants and a helper function of the track block interlock.
package tbi_pkg;

    localparam int SECONDS_W        = 12;
    localparam int ELAPSED_W        = 22;
    localparam int TICKS_PER_SECOND = 1000;
    localparam int TICKS_W          = $clog2(TICKS_PER_SECOND + 1);
    localparam int PROD_W           = SECONDS_W + TICKS_W;
    localparam int CALC_W           = (PROD_W > ELAPSED_W) ? PROD_W : ELAPSED_W;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
    localparam logic [SECONDS_W-1:0] RESET_SECONDS = SECONDS_W'(30);

    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_APPROACHING = 3'd1,
        OP_ENTER       = 3'd2,
        OP_SET         = 3'd3,
        OP_LEFT        = 3'd4,
        OP_RESET_STOP  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_STOP   = 2'd1,
        MODE_MANUAL = 2'd2,
        MODE_AUTO   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_FREE      = 3'd0,
        ST_EXPECTING = 3'd1,
        ST_ENTERED   = 3'd2,
        ST_BLOCKED   = 3'd3,
        ST_LEAVING   = 3'd4
    } status_t;

    typedef struct packed {
        op_t   operation;
        mode_t mode;
        logic  override_pressed;
        logic  next_free;
    } item_t;

    typedef struct packed {
        status_t status_code;
        logic    approach_lamp;
        logic    block_lamp;
        logic    brake_release;
        logic    timeout_error;
    } result_t;

    // Release limit in ticks, clamped to the range of the release timer.
    function automatic logic [ELAPSED_W-1:0] release_limit(input logic [SECONDS_W-1:0] seconds);
        logic [CALC_W-1:0] prod;
        begin
            prod = CALC_W'(seconds) * CALC_W'(TICKS_PER_SECOND);
            if (prod > CALC_W'(ELAPSED_MAX))
            begin
                release_limit = ELAPSED_MAX;
            end
            else
            begin
                release_limit = prod[ELAPSED_W-1:0];
            end
        end
    endfunction

endpackage

// File: design/tbi_input_stage.sv
// Input register that holds one accepted item until the core takes it.
module tbi_input_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tbi_pkg::item_t item,
    input  logic          advance,
    output logic          held_valid,
    output tbi_pkg::item_t held_item
);

    logic           valid_reg;
    logic           valid_next;
    tbi_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// File: design/tbi_core.sv
// Interlock state, release timer and the per-item state update.
module tbi_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [tbi_pkg::SECONDS_W-1:0]   cfg_seconds,
    input  logic                            advance,
    input  tbi_pkg::item_t                  item,
    output tbi_pkg::result_t                result
);

    tbi_pkg::status_t                st_reg;
    tbi_pkg::status_t                st_next;
    logic                            rel_reg;
    logic                            rel_next;
    logic                            man_reg;
    logic                            man_next;
    logic [tbi_pkg::ELAPSED_W-1:0]   el_reg;
    logic [tbi_pkg::ELAPSED_W-1:0]   el_next;
    logic [tbi_pkg::ELAPSED_W-1:0]   limit_reg;
    logic [tbi_pkg::ELAPSED_W-1:0]   el_tick;
    logic                            err;
    logic                            may_release;

    assign el_tick = (rel_reg && el_reg != tbi_pkg::ELAPSED_MAX) ?
                     el_reg + tbi_pkg::ELAPSED_W'(1) : el_reg;

    always_comb
    begin
        st_next     = st_reg;
        rel_next    = rel_reg;
        man_next    = man_reg;
        el_next     = el_reg;
        err         = 1'b0;
        may_release = (item.mode == tbi_pkg::MODE_AUTO) || man_reg;
        case (item.operation)
            tbi_pkg::OP_TICK:
            begin
                el_next = el_tick;
                case (item.mode)
                    tbi_pkg::MODE_MANUAL:
                    begin
                        if (item.override_pressed)
                        begin
                            if (!man_reg)
                            begin
                                man_next = 1'b1;
                                rel_next = 1'b1;
                                el_next  = '0;
                                if (st_reg == tbi_pkg::ST_BLOCKED)
                                begin
                                    st_next = tbi_pkg::ST_LEAVING;
                                end
                            end
                        end
                        else if (man_reg)
                        begin
                            man_next = 1'b0;
                            rel_next = 1'b0;
                            el_next  = '0;
                        end
                    end
                    tbi_pkg::MODE_AUTO:
                    begin
                        man_next = 1'b0;
                        if (rel_reg && el_tick >= limit_reg)
                        begin
                            rel_next = 1'b0;
                            el_next  = '0;
                            err      = 1'b1;
                        end
                    end
                    default:
                    begin
                        man_next = 1'b0;
                        if (rel_reg)
                        begin
                            rel_next = 1'b0;
                            el_next  = '0;
                        end
                    end
                endcase
            end
            tbi_pkg::OP_APPROACHING:
            begin
                st_next = tbi_pkg::ST_EXPECTING;
            end
            tbi_pkg::OP_ENTER:
            begin
                st_next = tbi_pkg::ST_ENTERED;
            end
            tbi_pkg::OP_SET:
            begin
                if (st_reg inside {tbi_pkg::ST_FREE, tbi_pkg::ST_EXPECTING,
                                   tbi_pkg::ST_ENTERED})
                begin
                    st_next = tbi_pkg::ST_BLOCKED;
                end
            end
            tbi_pkg::OP_LEFT:
            begin
                if (st_reg == tbi_pkg::ST_LEAVING)
                begin
                    st_next = tbi_pkg::ST_FREE;
                end
            end
            tbi_pkg::OP_RESET_STOP:
            begin
                if ((st_reg inside {tbi_pkg::ST_ENTERED, tbi_pkg::ST_LEAVING} ||
                     (st_reg == tbi_pkg::ST_BLOCKED && item.next_free)) && may_release)
                begin
                    rel_next = 1'b1;
                    el_next  = '0;
                    if (st_reg == tbi_pkg::ST_BLOCKED)
                    begin
                        st_next = tbi_pkg::ST_LEAVING;
                    end
                end
            end
            default:
            begin
                st_next = st_reg;
            end
        endcase
    end

    always_comb
    begin
        result.status_code   = st_next;
        result.approach_lamp = st_next inside {tbi_pkg::ST_EXPECTING, tbi_pkg::ST_ENTERED,
                                               tbi_pkg::ST_LEAVING};
        result.block_lamp    = st_next inside {tbi_pkg::ST_BLOCKED, tbi_pkg::ST_LEAVING};
        result.brake_release = rel_next;
        result.timeout_error = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= tbi_pkg::ST_FREE;
            rel_reg   <= 1'b0;
            man_reg   <= 1'b0;
            el_reg    <= '0;
            limit_reg <= tbi_pkg::release_limit(tbi_pkg::RESET_SECONDS);
        end
        else
        begin
            if (advance)
            begin
                st_reg  <= st_next;
                rel_reg <= rel_next;
                man_reg <= man_next;
                el_reg  <= el_next;
            end
            if (cfg_write)
            begin
                limit_reg <= tbi_pkg::release_limit(cfg_seconds);
            end
        end
    end

`ifndef SYNTH
    a_timer_idle_when_holding: assert property (@(posedge clk) disable iff (!rst_n)
        !rel_reg |-> el_reg == '0)
        else $error("release timer runs while the brake holds");

    a_manual_implies_released: assert property (@(posedge clk) disable iff (!rst_n)
        man_reg |-> rel_reg)
        else $error("manual override active with the brake holding");

    a_timeout_holds_brake: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.timeout_error) |=> (!rel_reg && el_reg == '0))
        else $error("timeout did not put the brake back to holding");

    a_timeout_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        result.timeout_error |-> (item.operation == tbi_pkg::OP_TICK &&
                                  item.mode == tbi_pkg::MODE_AUTO))
        else $error("timeout raised outside an auto mode tick");

    a_state_holds_without_item: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(st_reg) && $stable(rel_reg) && $stable(man_reg) &&
                      $stable(el_reg)))
        else $error("interlock state changed without an item");
`endif

endmodule

// File: design/tbi_output_stage.sv
// Result register that holds one result item until it is taken.
module tbi_output_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  tbi_pkg::result_t result,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_ready,
    output tbi_pkg::result_t held_result
);

    logic             valid_reg;
    logic             valid_next;
    tbi_pkg::result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid   = valid_reg;
    assign held_result = result_reg;

endmodule

// File: design/track_block_interlock.sv
// Top level of the track block interlock.
// An accepted item is held in the input register, and its result in the result register.
// Throughput: one item per cycle while out_ready is high; the input register and
// the result register let a new item enter while a finished result waits to be taken.
// Reset (rst_n, asynchronous, active low) clears the status to free, holds the brake,
// clears the override flag and the timer, and sets the release limit to 30 seconds.
module track_block_interlock (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    operation,
    input  logic [1:0]                    mode,
    input  logic                          override_pressed,
    input  logic                          next_free,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status_code,
    output logic                          approach_lamp,
    output logic                          block_lamp,
    output logic                          brake_release,
    output logic                          timeout_error,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tbi_pkg::SECONDS_W-1:0] max_release_seconds
);

    tbi_pkg::item_t   in_item;
    tbi_pkg::item_t   held_item;
    tbi_pkg::result_t core_result;
    tbi_pkg::result_t out_result;
    logic             held_valid;
    logic             can_load;
    logic             advance;

    assign in_item.operation        = tbi_pkg::op_t'(operation);
    assign in_item.mode             = tbi_pkg::mode_t'(mode);
    assign in_item.override_pressed = override_pressed;
    assign in_item.next_free        = next_free;

    assign advance   = held_valid && can_load;
    assign cfg_ready = 1'b1;

    tbi_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item       (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    tbi_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_seconds (max_release_seconds),
        .advance     (advance),
        .item        (held_item),
        .result      (core_result)
    );

    tbi_output_stage u_output (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .result      (core_result),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .held_result (out_result)
    );

    assign status_code   = out_result.status_code;
    assign approach_lamp = out_result.approach_lamp;
    assign block_lamp    = out_result.block_lamp;
    assign brake_release = out_result.brake_release;
    assign timeout_error = out_result.timeout_error;

endmodule

// File: verif/tb_track_block_interlock.sv
// Self-checking testbench for the track block interlock with a built-in predictor.
module tb_track_block_interlock;
    timeunit 1ns;
    timeprecision 1ps;

    import tbi_pkg::*;

    typedef struct packed {
        logic [2:0] op;
        mode_t      mode;
        logic       pressed;
        logic       next_free;
    } event_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [2:0]           operation = '0;
    logic [1:0]           mode = '0;
    logic                 override_pressed = 1'b0;
    logic                 next_free = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [2:0]           status_code;
    logic                 approach_lamp;
    logic                 block_lamp;
    logic                 brake_release;
    logic                 timeout_error;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [SECONDS_W-1:0] max_release_seconds = '0;

    // Predicted state of the interlock.
    status_t              track_status;
    logic                 brake_open;
    logic                 manual_on;
    logic [ELAPSED_W-1:0] elapsed_ticks;
    logic [SECONDS_W-1:0] limit_seconds;

    event_t  pending_events[$];
    result_t expected_results[$];
    event_t  on_port;
    int      burst_left = 1;
    int      gap_left = 0;
    logic    wait_for_drain = 1'b0;
    logic [15:0] stall_mask = 16'hFFFF;
    int      stall_pos = 0;
    int      mismatches = 0;
    int      items_sent = 0;
    int      results_checked = 0;
    int      expiries_seen = 0;
    int      limits_written = 0;
    int      queued_items = 0;

    track_block_interlock i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .operation          (operation),
        .mode               (mode),
        .override_pressed   (override_pressed),
        .next_free          (next_free),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status_code        (status_code),
        .approach_lamp      (approach_lamp),
        .block_lamp         (block_lamp),
        .brake_release      (brake_release),
        .timeout_error      (timeout_error),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .max_release_seconds(max_release_seconds)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [ELAPSED_W-1:0] limit_ticks();
        longint unsigned ticks;
        ticks = longint'(limit_seconds) * 64'd1000;
        if (ticks > ELAPSED_MAX)
        begin
            return ELAPSED_MAX;
        end
        return ELAPSED_W'(ticks);
    endfunction

    function automatic void hold_brake();
        brake_open = 1'b0;
        elapsed_ticks = '0;
    endfunction

    function automatic void try_release(input mode_t req_mode);
        if (req_mode == MODE_AUTO || manual_on)
        begin
            brake_open = 1'b1;
            elapsed_ticks = '0;
            if (track_status == ST_BLOCKED)
            begin
                track_status = ST_LEAVING;
            end
        end
    endfunction

    function automatic result_t interlock_step(input event_t ev);
        result_t res;
        logic    expired;
        expired = 1'b0;
        case (ev.op)
            OP_TICK:
            begin
                if (brake_open && elapsed_ticks != ELAPSED_MAX)
                begin
                    elapsed_ticks = elapsed_ticks + 1'b1;
                end
                if (ev.mode == MODE_OFF || ev.mode == MODE_STOP)
                begin
                    manual_on = 1'b0;
                    if (brake_open)
                    begin
                        hold_brake();
                    end
                end
                else if (ev.mode == MODE_MANUAL)
                begin
                    if (ev.pressed)
                    begin
                        if (!manual_on)
                        begin
                            manual_on = 1'b1;
                            try_release(ev.mode);
                        end
                    end
                    else if (manual_on)
                    begin
                        manual_on = 1'b0;
                        hold_brake();
                    end
                end
                else
                begin
                    manual_on = 1'b0;
                    if (brake_open && elapsed_ticks >= limit_ticks())
                    begin
                        hold_brake();
                        expired = 1'b1;
                    end
                end
            end
            OP_APPROACHING:
            begin
                track_status = ST_EXPECTING;
            end
            OP_ENTER:
            begin
                track_status = ST_ENTERED;
            end
            OP_SET:
            begin
                if (track_status == ST_FREE || track_status == ST_EXPECTING ||
                    track_status == ST_ENTERED)
                begin
                    track_status = ST_BLOCKED;
                end
            end
            OP_LEFT:
            begin
                if (track_status == ST_LEAVING)
                begin
                    track_status = ST_FREE;
                end
            end
            OP_RESET_STOP:
            begin
                if (track_status == ST_ENTERED || track_status == ST_LEAVING ||
                    (track_status == ST_BLOCKED && ev.next_free))
                begin
                    try_release(ev.mode);
                end
            end
            default:
            begin
            end
        endcase
        res.status_code   = track_status;
        res.approach_lamp = (track_status == ST_EXPECTING || track_status == ST_ENTERED ||
                             track_status == ST_LEAVING);
        res.block_lamp    = (track_status == ST_BLOCKED || track_status == ST_LEAVING);
        res.brake_release = brake_open;
        res.timeout_error = expired;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Sender: bursts of items with random gaps, and now and then a full drain.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                expected_results.push_back(interlock_step(on_port));
                items_sent++;
            end
            if (wait_for_drain && expected_results.size() != 0)
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                wait_for_drain = 1'b0;
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_events.size() != 0)
                begin
                    on_port = pending_events.pop_front();
                    operation        <= on_port.op;
                    mode             <= on_port.mode;
                    override_pressed <= on_port.pressed;
                    next_free        <= on_port.next_free;
                    in_valid         <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                        wait_for_drain = ($urandom_range(0, 29) == 0);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls follow a 16-bit mask that is redrawn after each pass.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with nothing expected", status_code, 0);
                end
                else
                begin
                    result_t want;
                    want = expected_results.pop_front();
                    results_checked++;
                    if (want.timeout_error)
                    begin
                        expiries_seen++;
                    end
                    if (status_code !== want.status_code)
                    begin
                        report_mismatch("status_code", status_code, want.status_code);
                    end
                    if (approach_lamp !== want.approach_lamp)
                    begin
                        report_mismatch("approach_lamp", approach_lamp, want.approach_lamp);
                    end
                    if (block_lamp !== want.block_lamp)
                    begin
                        report_mismatch("block_lamp", block_lamp, want.block_lamp);
                    end
                    if (brake_release !== want.brake_release)
                    begin
                        report_mismatch("brake_release", brake_release, want.brake_release);
                    end
                    if (timeout_error !== want.timeout_error)
                    begin
                        report_mismatch("timeout_error", timeout_error, want.timeout_error);
                    end
                end
            end
            out_ready <= stall_mask[stall_pos];
            if (stall_pos == 15)
            begin
                stall_pos = 0;
                case ($urandom_range(0, 3))
                    0: stall_mask = 16'hFFFF;
                    1: stall_mask = 16'($urandom) | 16'h0001;
                    2: stall_mask = 16'($urandom) & 16'($urandom) | 16'h8000;
                    default: stall_mask = 16'($urandom) | 16'($urandom);
                endcase
            end
            else
            begin
                stall_pos++;
            end
        end
    end

    task automatic push_event(input logic [2:0] op, input mode_t ev_mode,
                              input logic pressed, input logic nxt);
        event_t ev;
        ev.op = op;
        ev.mode = ev_mode;
        ev.pressed = pressed;
        ev.next_free = nxt;
        pending_events.push_back(ev);
        queued_items++;
    endtask

    function automatic mode_t pick_mode();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
        begin
            return MODE_AUTO;
        end
        if (roll < 7)
        begin
            return MODE_MANUAL;
        end
        return mode_t'($urandom_range(0, 3));
    endfunction

    task automatic push_random(input logic [2:0] op, input mode_t ev_mode);
        push_event(op, ev_mode, 1'($urandom), 1'($urandom));
    endtask

    task automatic push_ticks(input int count);
        for (int k = 0; k < count; k++)
        begin
            push_random(OP_TICK, pick_mode());
        end
    endtask

    // One train passing the block, with random choices along the way.
    task automatic push_train_pass();
        push_random(OP_APPROACHING, pick_mode());
        push_ticks($urandom_range(0, 3));
        push_random(OP_ENTER, pick_mode());
        if ($urandom_range(0, 2) != 0)
        begin
            push_random(OP_SET, pick_mode());
        end
        if ($urandom_range(0, 3) == 0)
        begin
            push_event(OP_TICK, MODE_MANUAL, 1'b1, 1'($urandom));
        end
        push_ticks($urandom_range(0, 2));
        push_event(OP_RESET_STOP, pick_mode(), 1'($urandom), $urandom_range(0, 3) != 0);
        push_ticks($urandom_range(0, 6));
        if ($urandom_range(0, 4) != 0)
        begin
            push_random(OP_LEFT, pick_mode());
        end
        push_ticks($urandom_range(0, 3));
    endtask

    task automatic push_random_phase(input int count);
        int target;
        target = queued_items + count;
        while (queued_items < target)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                push_train_pass();
            end
            else
            begin
                for (int k = $urandom_range(1, 4); k > 0; k--)
                begin
                    push_random(3'($urandom_range(0, 7)), mode_t'($urandom_range(0, 3)));
                end
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_release_limit(input logic [SECONDS_W-1:0] seconds);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        max_release_seconds <= seconds;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        limit_seconds = seconds;
        limits_written++;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        track_status  = ST_FREE;
        brake_open    = 1'b0;
        manual_on     = 1'b0;
        elapsed_ticks = '0;
        limit_seconds = RESET_SECONDS;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_event(OP_TICK, MODE_OFF, 1'b1, 1'b1);
        push_event(3'd6, MODE_AUTO, 1'b0, 1'b1);
        push_event(3'd7, MODE_MANUAL, 1'b1, 1'b0);
        push_event(OP_LEFT, MODE_AUTO, 1'b0, 1'b0);
        push_event(OP_SET, MODE_STOP, 1'b0, 1'b0);
        push_event(OP_RESET_STOP, MODE_AUTO, 1'b1, 1'b0);
        push_event(OP_RESET_STOP, MODE_AUTO, 1'b0, 1'b1);
        push_event(OP_RESET_STOP, MODE_AUTO, 1'b0, 1'b0);
        push_event(OP_TICK, MODE_AUTO, 1'b1, 1'b0);
        push_event(OP_TICK, MODE_STOP, 1'b0, 1'b1);
        push_event(OP_LEFT, MODE_OFF, 1'b1, 1'b1);
        push_event(OP_APPROACHING, MODE_OFF, 1'b0, 1'b0);
        push_event(OP_SET, MODE_MANUAL, 1'b1, 1'b1);
        push_event(OP_SET, MODE_AUTO, 1'b0, 1'b1);
        push_event(OP_ENTER, MODE_STOP, 1'b1, 1'b0);
        push_event(OP_RESET_STOP, MODE_OFF, 1'b1, 1'b1);
        push_event(OP_TICK, MODE_MANUAL, 1'b1, 1'b0);
        push_event(OP_TICK, MODE_MANUAL, 1'b1, 1'b1);
        push_event(OP_RESET_STOP, MODE_MANUAL, 1'b0, 1'b0);
        push_event(OP_TICK, MODE_MANUAL, 1'b0, 1'b0);
        push_event(OP_SET, MODE_OFF, 1'b0, 1'b0);
        push_event(OP_TICK, MODE_MANUAL, 1'b1, 1'b0);
        push_event(OP_TICK, MODE_AUTO, 1'b1, 1'b1);
        push_event(OP_LEFT, MODE_AUTO, 1'b0, 1'b0);

        write_release_limit('0);
        push_event(OP_ENTER, MODE_AUTO, 1'b0, 1'b0);
        push_event(OP_RESET_STOP, MODE_AUTO, 1'b0, 1'b0);
        push_event(OP_TICK, MODE_AUTO, 1'b0, 1'b0);
        push_random_phase(200);

        // A release in auto mode that stays inside a one second limit.
        write_release_limit(SECONDS_W'(1));
        push_event(OP_ENTER, MODE_AUTO, 1'b0, 1'b0);
        push_event(OP_RESET_STOP, MODE_AUTO, 1'b0, 1'b1);
        for (int k = 0; k < 20; k++)
        begin
            push_event(OP_TICK, MODE_AUTO, 1'($urandom), 1'($urandom));
        end

        write_release_limit({SECONDS_W{1'b1}});
        push_random_phase(200);
        write_release_limit(SECONDS_W'(2));
        push_random_phase(130);
        write_release_limit(SECONDS_W'($urandom_range(0, 3)));
        push_random_phase(130);

        wait_idle();
        repeat (10) @(posedge clk);
        $display("Checked %0d results for %0d items over %0d release limits.",
                 results_checked, items_sent, limits_written);
        $display("Release expiries seen: %0d; mismatches: %0d.", expiries_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("track_block_interlock regression: pass");
        end
        else
        begin
            $display("track_block_interlock regression: fail");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("track_block_interlock regression: fail");
        $finish;
    end

endmodule
